// ----- hw/rtl/qse_pkg.sv -----
package qse_pkg;

  // Width of the value fields on both channels.
  localparam int FIELD_W = 32;

  localparam int DEF_CAPACITY   = 1024;
  localparam int DEF_DATA_WIDTH = 32;

  // Action codes of an input beat.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Requests from the front end to the sort core.
  typedef struct packed {
    logic start;
    logic wr_en;
    logic rd_en;
  } qse_ctl_t;

  // Status from the sort core.
  typedef struct packed {
    logic busy;
    logic done;
  } qse_sts_t;

endpackage

// ----- hw/rtl/qse_in_if.sv -----
interface qse_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [qse_pkg::FIELD_W-1:0]  value;
  logic                         last;

  modport source (output valid, action, value, last, input ready);
  modport sink   (input valid, action, value, last, output ready);
endinterface

// ----- hw/rtl/qse_out_if.sv -----
interface qse_out_if;
  logic                         valid;
  logic                         ready;
  logic                         valid_res;
  logic [qse_pkg::FIELD_W-1:0]  result_value;
  logic                         final_res;
  logic                         overflow;

  modport source (output valid, valid_res, result_value, final_res, overflow, input ready);
  modport sink   (input valid, valid_res, result_value, final_res, overflow, output ready);
endinterface

// ----- hw/rtl/qse_sort_core.sv -----
module qse_sort_core #(
  parameter int CAPACITY   = qse_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = qse_pkg::DEF_DATA_WIDTH,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qse_pkg::qse_ctl_t      ctl,
  input  logic [AW-1:0]          host_wr_addr,
  input  logic [DATA_WIDTH-1:0]  host_wr_data,
  input  logic [AW-1:0]          host_rd_addr,
  input  logic [CW-1:0]          host_count,
  output qse_pkg::qse_sts_t      sts,
  output logic [DATA_WIDTH-1:0]  rd_data
);
  import qse_pkg::*;

  // Only the larger part of a split is stacked, so AW+1 slots always suffice.
  localparam int SD  = AW + 1;
  localparam int SPW = $clog2(SD + 1);
  localparam int SIW = $clog2(SD);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_RANGE  = 10'b00_0000_0010,
    S_PIVOT  = 10'b00_0000_0100,
    S_LREQ   = 10'b00_0000_1000,
    S_LCHK   = 10'b00_0001_0000,
    S_RCHK   = 10'b00_0010_0000,
    S_DECIDE = 10'b00_0100_0000,
    S_SWAP   = 10'b00_1000_0000,
    S_PWAIT  = 10'b01_0000_0000,
    S_PLACE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic [CW-1:0] l_r, l_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [DATA_WIDTH-1:0] piv_r, piv_nxt;
  logic [DATA_WIDTH-1:0] el_r, el_nxt;
  logic [DATA_WIDTH-1:0] er_r, er_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] stk_lo [SD];
  logic [CW-1:0] stk_end [SD];

  logic                  mem_wr_en, mem_rd_en;
  logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic                  push_en;
  logic [CW-1:0]         push_lo, push_end;
  logic                  done;

  logic          lt;
  logic [CW-1:0] size, lsize, rsize, l_inc, r_dec, r_inc;
  logic [SPW-1:0] sp_dec;

  // The one shared comparator: registered read data against the pivot.
  assign lt     = $signed(rd_data_r) < $signed(piv_r);
  assign size   = end_r - lo_r;
  assign l_inc  = l_r + 1'b1;
  assign r_dec  = r_r - 1'b1;
  assign r_inc  = r_r + 1'b1;
  assign lsize  = r_r - lo_r;
  assign rsize  = end_r - r_inc;
  assign sp_dec = sp_r - 1'b1;

  always_comb begin
    state_nxt   = state_r;
    lo_nxt      = lo_r;
    end_nxt     = end_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    piv_nxt     = piv_r;
    el_nxt      = el_r;
    er_nxt      = er_r;
    sp_nxt      = sp_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = host_wr_addr;
    mem_wr_data = host_wr_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = host_rd_addr;
    push_en     = 1'b0;
    push_lo     = r_inc;
    push_end    = end_r;
    done        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        mem_wr_en = ctl.wr_en;
        mem_rd_en = ctl.rd_en;
        if (ctl.start) begin
          lo_nxt    = '0;
          end_nxt   = host_count;
          sp_nxt    = '0;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (size < CW'(2)) begin
          if (sp_r == '0) begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            lo_nxt  = stk_lo[sp_dec[SIW-1:0]];
            end_nxt = stk_end[sp_dec[SIW-1:0]];
            sp_nxt  = sp_dec;
          end
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = lo_r[AW-1:0];
          l_nxt       = lo_r + 1'b1;
          r_nxt       = end_r - 1'b1;
          state_nxt   = S_PIVOT;
        end
      end
      S_PIVOT: begin
        piv_nxt   = rd_data_r;
        state_nxt = S_LREQ;
      end
      S_LREQ: begin
        if (l_r <= r_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = l_r[AW-1:0];
          state_nxt   = S_LCHK;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_LCHK: begin
        if (lt) begin
          l_nxt = l_inc;
          if (l_r < r_r) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = l_inc[AW-1:0];
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          el_nxt      = rd_data_r;
          mem_rd_en   = 1'b1;
          mem_rd_addr = r_r[AW-1:0];
          state_nxt   = S_RCHK;
        end
      end
      S_RCHK: begin
        if (!lt) begin
          r_nxt = r_dec;
          if (l_r < r_r) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = r_dec[AW-1:0];
          end else begin
            state_nxt = S_DECIDE;
          end
        end else begin
          er_nxt    = rd_data_r;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (r_r < l_r) begin
          // Scans have crossed: fetch the word that trades places with the pivot.
          mem_rd_en   = 1'b1;
          mem_rd_addr = r_r[AW-1:0];
          state_nxt   = S_PWAIT;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = r_r[AW-1:0];
          mem_wr_data = el_r;
          state_nxt   = S_SWAP;
        end
      end
      S_SWAP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = l_r[AW-1:0];
        mem_wr_data = er_r;
        state_nxt   = S_LREQ;
      end
      S_PWAIT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = lo_r[AW-1:0];
        mem_wr_data = rd_data_r;
        state_nxt   = S_PLACE;
      end
      S_PLACE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = r_r[AW-1:0];
        mem_wr_data = piv_r;
        // Carry on with the smaller part; the larger one waits on the stack.
        if (lsize <= rsize) begin
          push_lo  = r_inc;
          push_end = end_r;
          push_en  = rsize >= CW'(2);
          end_nxt  = r_r;
        end else begin
          push_lo  = lo_r;
          push_end = r_r;
          push_en  = lsize >= CW'(2);
          lo_nxt   = r_inc;
        end
        if (push_en) begin
          sp_nxt = sp_r + 1'b1;
        end
        state_nxt = S_RANGE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    end_r <= end_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    piv_r <= piv_nxt;
    el_r  <= el_nxt;
    er_r  <= er_nxt;
    if (push_en) begin
      stk_lo[sp_r[SIW-1:0]]  <= push_lo;
      stk_end[sp_r[SIW-1:0]] <= push_end;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= mem[mem_rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign sts.busy  = (state_r != S_IDLE);
  assign sts.done  = done;

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == S_IDLE)
    else $error("sort started while the core was busy");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LCHK || state_r == S_RCHK) |-> l_r <= r_r)
    else $error("scan pointers crossed while a compare was pending");

  a_right_above_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE || state_r == S_PWAIT || state_r == S_PLACE) |-> r_r >= lo_r)
    else $error("right scan ran below the range start");

  a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(SD))
    else $error("range stack overran its slots");
`endif

endmodule

// ----- hw/rtl/quicksort_engine_unit.sv -----
// Channel     Dir  Payload                                         Beat when
// in_stream   in   action, value, last                             valid && ready
// out_stream  out  valid_res, result_value, final_res, overflow    valid && ready
//
// A load beat is written straight into the element store; a fetch result passes through the
// core's read register and then the output register. The load marked last starts the sort.
// in_stream.ready stays low while the sort runs or a fetch result is on its way.
// rst_n is synchronous and active low; the element store needs no clearing.
// A result held on out_stream blocks every beat behind it until it is taken.
module quicksort_engine_unit #(
  parameter int CAPACITY   = qse_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = qse_pkg::DEF_DATA_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  qse_in_if.sink     in_stream,
  qse_out_if.source  out_stream
);
  import qse_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  qse_ctl_t ctl;
  qse_sts_t sts;

  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  logic [CW-1:0]         start_count;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rp_r, rp_nxt;
  logic          sorted_r, sorted_nxt;
  logic          ovf_r, ovf_nxt;
  logic          fetch_wait_r, fetch_wait_nxt;
  logic          hit_r, hit_nxt;
  logic          final_r, final_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_res_r;
  logic [FIELD_W-1:0] out_value_r;
  logic          out_final_r;
  logic          out_ovf_r;

  logic          in_ready, accept;
  logic [CW-1:0] eff_count, rp_inc;
  logic [DATA_WIDTH+FIELD_W-1:0] in_ext, out_ext;

  assign in_ready = !sts.busy && !fetch_wait_r && (!out_valid_r || out_stream.ready);
  assign accept   = in_stream.valid && in_ready;

  // Resize between the fixed port width and the stored element width.
  assign in_ext  = {{DATA_WIDTH{1'b0}}, in_stream.value};
  assign out_ext = {{FIELD_W{1'b0}}, rd_data};
  assign wr_data = in_ext[DATA_WIDTH-1:0];

  // A load after a finished sort starts a fresh set from the first slot.
  assign eff_count = sorted_r ? '0 : count_r;
  assign rp_inc    = rp_r + 1'b1;

  always_comb begin
    ctl            = '0;
    wr_addr        = eff_count[AW-1:0];
    rd_addr        = rp_r[AW-1:0];
    start_count    = count_r;
    count_nxt      = count_r;
    rp_nxt         = rp_r;
    sorted_nxt     = sorted_r;
    ovf_nxt        = ovf_r;
    fetch_wait_nxt = 1'b0;
    hit_nxt        = hit_r;
    final_nxt      = final_r;
    if (sts.done) begin
      sorted_nxt = 1'b1;
    end
    if (accept) begin
      if (in_stream.action == ACT_LOAD) begin
        if (sorted_r) begin
          sorted_nxt = 1'b0;
          rp_nxt     = '0;
        end
        if (eff_count < CW'(CAPACITY)) begin
          ctl.wr_en = 1'b1;
          count_nxt = eff_count + 1'b1;
        end else begin
          ovf_nxt   = 1'b1;
          count_nxt = eff_count;
        end
        if (in_stream.last) begin
          ctl.start   = 1'b1;
          start_count = count_nxt;
        end
      end else begin
        fetch_wait_nxt = 1'b1;
        if (sorted_r && (rp_r < count_r)) begin
          ctl.rd_en = 1'b1;
          hit_nxt   = 1'b1;
          final_nxt = (rp_inc == count_r);
          rp_nxt    = rp_inc;
        end else begin
          hit_nxt   = 1'b0;
          final_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fetch_wait_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      rp_r         <= '0;
      sorted_r     <= 1'b0;
      ovf_r        <= 1'b0;
      fetch_wait_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      rp_r         <= rp_nxt;
      sorted_r     <= sorted_nxt;
      ovf_r        <= ovf_nxt;
      fetch_wait_r <= fetch_wait_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    final_r <= final_nxt;
    if (fetch_wait_r) begin
      out_res_r   <= hit_r;
      out_value_r <= hit_r ? out_ext[FIELD_W-1:0] : '0;
      out_final_r <= final_r;
      out_ovf_r   <= ovf_r;
    end
  end

  qse_sort_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .host_wr_addr (wr_addr),
    .host_wr_data (wr_data),
    .host_rd_addr (rd_addr),
    .host_count   (start_count),
    .sts          (sts),
    .rd_data      (rd_data)
  );

  assign in_stream.ready         = in_ready;
  assign out_stream.valid        = out_valid_r;
  assign out_stream.valid_res    = out_res_r;
  assign out_stream.result_value = out_value_r;
  assign out_stream.final_res    = out_final_r;
  assign out_stream.overflow     = out_ovf_r;

`ifndef SYNTHESIS
  a_fetch_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_wait_r |=> out_valid_r)
    else $error("fetch result did not reach the output register");

  a_no_data_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !sorted_r)
    else $error("sorted flag set while the sort is still running");

  a_pointer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= count_r)
    else $error("read pointer ran past the element count");
`endif

endmodule

// ----- tb/quicksort_engine_unit_test.sv -----
`timescale 1ns / 1ps

module quicksort_engine_unit_test;
  import qse_pkg::*;

  localparam int SET_CAPACITY = DEF_CAPACITY;
  localparam int IDLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_QUOTA = 32;

  typedef struct packed {
    logic                action;
    logic [FIELD_W-1:0]  value;
    logic                last;
  } sort_beat_t;

  typedef struct packed {
    logic                valid_res;
    logic [FIELD_W-1:0]  result_value;
    logic                final_res;
    logic                overflow;
  } fetch_word_t;

  logic clk;
  logic rst_n;

  qse_in_if  in_stream ();
  qse_out_if out_stream ();

  quicksort_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

  // Shadow copy of the sorter's state.
  logic signed [FIELD_W-1:0] shadow_words [SET_CAPACITY];
  int unsigned               held_count;
  int unsigned               fetch_ptr;
  bit                        set_sorted;
  bit                        overflow_seen;

  sort_beat_t  beats_to_send [$];
  fetch_word_t sorted_words_due [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  recv_hold_cycles;
  bit  in_taken;
  int  quiet_cycles;
  int  mismatch_count;

  function automatic void sort_held_words();
    logic signed [FIELD_W-1:0] key;
    int j;
    for (int i = 1; i < int'(held_count); i++) begin
      key = shadow_words[i];
      j = i - 1;
      while (j >= 0 && shadow_words[j] > key) begin
        shadow_words[j + 1] = shadow_words[j];
        j--;
      end
      shadow_words[j + 1] = key;
    end
  endfunction

  function automatic void advance_sorter(sort_beat_t b);
    fetch_word_t r;
    if (b.action == ACT_LOAD) begin
      // A load after a sorted set opens a fresh set.
      if (set_sorted) begin
        set_sorted = 1'b0;
        held_count = 0;
        fetch_ptr  = 0;
      end
      if (held_count < SET_CAPACITY) begin
        shadow_words[held_count] = b.value;
        held_count++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (b.last) begin
        sort_held_words();
        set_sorted = 1'b1;
      end
    end else begin
      r = '0;
      if (set_sorted && fetch_ptr < held_count) begin
        r.valid_res    = 1'b1;
        r.result_value = shadow_words[fetch_ptr];
        r.final_res    = (fetch_ptr + 1 == held_count);
        fetch_ptr++;
      end
      r.overflow = overflow_seen;
      sorted_words_due.push_back(r);
    end
  endfunction

  task automatic queue_load(logic [FIELD_W-1:0] w, logic lst);
    sort_beat_t b;
    b.action = ACT_LOAD;
    b.value  = w;
    b.last   = lst;
    beats_to_send.push_back(b);
  endtask

  task automatic queue_fetches(int k);
    sort_beat_t b;
    for (int i = 0; i < k; i++) begin
      b.action = ACT_FETCH;
      b.value  = $urandom;
      b.last   = $urandom_range(1);
      beats_to_send.push_back(b);
    end
  endtask

  // Mostly well-formed sets, small ones far more often than large, with the odd
  // stray fetch in the middle of a set and the odd set left unterminated.
  task automatic queue_random_sets(int quota);
    int n, size_pick, style, extra, added;
    logic [FIELD_W-1:0] base, w;
    added = 0;
    while (added < quota) begin
      size_pick = $urandom_range(99);
      if (size_pick < 70) n = $urandom_range(12, 1);
      else if (size_pick < 95) n = $urandom_range(64, 13);
      else n = $urandom_range(300, 65);
      style = $urandom_range(4);
      base  = $urandom;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 8) begin
          queue_fetches(1);
          added++;
        end
        case (style)
          0: w = $urandom;
          1: w = $urandom_range(8) - 4;
          2: w = base + i;
          3: w = base - i;
          default: w = base;
        endcase
        queue_load(w, (i == n - 1) && ($urandom_range(99) >= 3));
      end
      if ($urandom_range(99) < 75) extra = n + $urandom_range(2);
      else extra = $urandom_range(n);
      queue_fetches(extra);
      added += n + extra;
    end
  endtask

  task automatic wait_queue_drained();
    while (beats_to_send.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: a beat is offered at the falling edge and held until it is taken.
  always @(negedge clk) begin
    sort_beat_t b;
    if (!rst_n) begin
      in_stream.valid <= 1'b0;
    end else if (!(in_stream.valid && !in_taken)) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = beats_to_send.pop_front();
        in_stream.action <= b.action;
        in_stream.value  <= b.value;
        in_stream.last   <= b.last;
        in_stream.valid  <= 1'b1;
      end else begin
        in_stream.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stream.ready <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      out_stream.ready <= 1'b0;
      recv_hold_cycles--;
    end else begin
      out_stream.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: both channels are observed at the rising edge.
  always @(posedge clk) begin
    sort_beat_t  b;
    fetch_word_t want;
    bit          out_taken;
    in_taken  = rst_n && in_stream.valid && in_stream.ready;
    out_taken = rst_n && out_stream.valid && out_stream.ready;
    if (in_taken) begin
      b.action = in_stream.action;
      b.value  = in_stream.value;
      b.last   = in_stream.last;
      advance_sorter(b);
    end
    if (out_taken) begin
      if (sorted_words_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: valid_res=%0b value=%0d final=%0b overflow=%0b",
                   out_stream.valid_res, $signed(out_stream.result_value),
                   out_stream.final_res, out_stream.overflow);
      end else begin
        want = sorted_words_due.pop_front();
        if (out_stream.valid_res !== want.valid_res ||
            out_stream.result_value !== want.result_value ||
            out_stream.final_res !== want.final_res ||
            out_stream.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result beat wrong: expected %0b/%0d/%0b/%0b, got %0b/%0d/%0b/%0b",
                     want.valid_res, $signed(want.result_value), want.final_res,
                     want.overflow, out_stream.valid_res,
                     $signed(out_stream.result_value), out_stream.final_res,
                     out_stream.overflow);
        end
      end
    end
    if (!rst_n || in_taken || out_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("quicksort_engine_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_stream.valid  = 1'b0;
    in_stream.action = ACT_LOAD;
    in_stream.value  = '0;
    in_stream.last   = 1'b0;
    out_stream.ready = 1'b0;
    held_count       = 0;
    fetch_ptr        = 0;
    set_sorted       = 1'b0;
    overflow_seen    = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    recv_hold_cycles = 0;
    in_taken         = 1'b0;
    quiet_cycles     = 0;
    mismatch_count   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fetch before anything is sorted, then a single-element set.
    queue_fetches(1);
    queue_load(32'h8000_0000, 1'b1);
    queue_fetches(2);
    // Extremes and a duplicate; the set is only partly read out.
    queue_load(32'h7FFF_FFFF, 1'b0);
    queue_load(32'h8000_0000, 1'b0);
    queue_load(32'h0000_0000, 1'b0);
    queue_load(32'hFFFF_FFFF, 1'b0);
    queue_load(32'h7FFF_FFFF, 1'b0);
    queue_load(32'h0000_0001, 1'b1);
    queue_fetches(3);
    // A load after that set starts a new one; a fetch mid-load returns nothing.
    queue_load(32'd5, 1'b0);
    queue_fetches(1);
    queue_load(-32'sd5, 1'b1);
    queue_fetches(3);
    queue_load(32'd7, 1'b0);
    queue_load(32'd7, 1'b1);
    queue_fetches(2);
    queue_random_sets(RANDOM_QUOTA);
    wait_queue_drained();

    send_idle_pct = 66;
    queue_random_sets(RANDOM_QUOTA);
    wait_queue_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 66;
    queue_random_sets(RANDOM_QUOTA);
    wait_queue_drained();

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    queue_random_sets(RANDOM_QUOTA);
    wait_queue_drained();

    // Hold the result side off once the first fetch is taken, so the block backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 40; i++) queue_load($urandom, i == 39);
    queue_fetches(48);
    while (beats_to_send.size() > 46) @(posedge clk);
    recv_hold_cycles = 300;
    wait_queue_drained();

    // Fill to capacity; the two extra loads are dropped, the second carrying last.
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    for (int i = 0; i < SET_CAPACITY + 2; i++) begin
      if (i % 200 == 0) queue_load(32'h8000_0000, 1'b0);
      else if (i % 200 == 1) queue_load(32'h7FFF_FFFF, 1'b0);
      else queue_load($urandom, i == SET_CAPACITY + 1);
    end
    queue_fetches(24);
    wait_queue_drained();

    while (in_stream.valid) @(posedge clk);
    while (sorted_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sorted_words_due.size() == 0) begin
      $display("quicksort_engine_unit: match");
    end else begin
      $display("quicksort_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
